@@ rtl/smrg_pkg.sv @@
// ----------------------------------------------------------------------------
// smrg_pkg
// Shared types and constants for the stencil matrix row generator: register
// indexes, item kinds, sequencer states and the sequencer control word.
// ----------------------------------------------------------------------------
package smrg_pkg;

    // field widths fixed by the interface
    localparam int GS_W   = 9;
    localparam int SS_W   = 3;
    localparam int ROW_W  = 16;
    localparam int SLOT_W = 5;
    localparam int WORD_W = 64;

    // largest sides the datapath widths are built for
    localparam int STENCIL_SIDE_MAX = 5;
    localparam int GRID_SIDE_MAX    = 256;

    // configuration register indexes
    localparam logic REG_GRID_SIDE    = 1'b0;
    localparam logic REG_STENCIL_SIDE = 1'b1;

    // item kinds
    localparam logic KIND_LOAD     = 1'b0;
    localparam logic KIND_GENERATE = 1'b1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_WALK,
        ST_DRAIN,
        ST_FLUSH
    } state_t;

    // sequencer control word
    typedef struct packed {
        logic item_ready;
        logic tbl_we;
        logic issue;
        logic out_load;
        logic out_from_s1;
        logic out_last;
        logic pend_load;
        logic pend_clear;
    } ctl_t;

endpackage

@@ rtl/stencil_matrix_row_generator.sv @@
// ----------------------------------------------------------------------------
// stencil_matrix_row_generator
// Holds a square stencil coefficient table in a small synchronous memory and
// expands one grid point into the nonzero entries of its sparse matrix row.
// ----------------------------------------------------------------------------
//
//  channel   signals                                   word
//  -------   ---------------------------------------   ----------------------
//  item      item_valid / item_ready                   kind, coef_slot,
//                                                      coef_word, grid_row
//  result    result_valid / result_ready               matrix_row,
//                                                      matrix_column,
//                                                      entry_word, last_entry
//  cfg       cfg_valid / cfg_ready                     cfg_index, cfg_data
//
// a load word writes the coefficient memory when it is accepted. a generate
// word passes its accept cycle, the bit-serial divider (row split into grid
// row and column), one stencil entry read from the coefficient memory per
// cycle while the result is not stalled, then the drain and, if needed, flush
// states. a row outside the grid ends after the divider with no result.
// reset clears control state and loads grid_side 16, stencil_side 3; the
// coefficient memory is not cleared. a stalled result holds the walk in place.
// ----------------------------------------------------------------------------
module stencil_matrix_row_generator
    import smrg_pkg::*;
#(
    parameter int COEF_WIDTH       = 64
)
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                item_valid,
    output logic                item_ready,
    input  logic                kind,
    input  logic [SLOT_W-1:0]   coef_slot,
    input  logic [WORD_W-1:0]   coef_word,
    input  logic [ROW_W-1:0]    grid_row,

    output logic                result_valid,
    input  logic                result_ready,
    output logic [ROW_W-1:0]    matrix_row,
    output logic [ROW_W-1:0]    matrix_column,
    output logic [WORD_W-1:0]   entry_word,
    output logic                last_entry,

    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [GS_W-1:0]     cfg_data
);

    localparam int TBL_DEPTH = STENCIL_SIDE_MAX * STENCIL_SIDE_MAX;
    localparam int TBL_AW    = (TBL_DEPTH > 1) ? $clog2(TBL_DEPTH) : 1;

    // configuration registers
    logic [GS_W-1:0]        grid_side_reg;
    logic [SS_W-1:0]        stencil_side_reg;

    // sequencer
    state_t                 state_reg, state_next;
    ctl_t                   ctl;
    logic                   en;

    // divider
    logic [ROW_W-1:0]       row_reg;
    logic [ROW_W-1:0]       dq_reg;
    logic [GS_W-1:0]        rem_reg;
    logic [3:0]             bit_cnt_reg;
    logic [GS_W:0]          trial;
    logic                   qbit;
    logic [GS_W-1:0]        rem_next;
    logic [ROW_W-1:0]       quo_next;

    // walker
    logic [SS_W-1:0]        px_reg, py_reg;
    logic [TBL_AW-1:0]      p_reg;
    logic signed [17:0]     yoff_reg;
    logic signed [4:0]      x_off, y_off;
    logic signed [11:0]     ncol, nrow;
    logic signed [17:0]     col_full;
    logic                   hit;
    logic                   walk_final;

    // read stage and pending entry
    logic                   s1_valid_reg;
    logic                   s1_hit_reg;
    logic [ROW_W-1:0]       s1_col_reg;
    logic [COEF_WIDTH-1:0]  rd_data_reg;
    logic                   pend_valid_reg;
    logic [ROW_W-1:0]       pend_col_reg;
    logic [COEF_WIDTH-1:0]  pend_word_reg;

    // coefficient memory
    logic [COEF_WIDTH-1:0]  coef_mem [TBL_DEPTH];

    // effective sizes
    logic [GS_W-1:0]        gs_eff;
    logic [SS_W-1:0]        ss_eff;
    logic [SS_W-1:0]        ss_m1;
    logic [SS_W-1:0]        half;
    logic [11:0]            half_gs;
    logic                   item_acc;
    logic                   gen_ok;

    assign gs_eff  = (32'(grid_side_reg) > GRID_SIDE_MAX) ? GS_W'(GRID_SIDE_MAX)
                                                          : grid_side_reg;
    assign ss_eff  = (32'(stencil_side_reg) > STENCIL_SIDE_MAX)
                     ? SS_W'(STENCIL_SIDE_MAX) : stencil_side_reg;
    assign ss_m1   = ss_eff - 3'd1;
    assign half    = ss_eff >> 1;
    assign half_gs = 12'(half) * 12'(gs_eff);

    assign item_ready = ctl.item_ready;
    assign cfg_ready  = 1'b1;
    assign item_acc   = item_valid && ctl.item_ready;
    assign gen_ok     = (gs_eff != '0) && (ss_eff != '0);
    assign en         = !result_valid || result_ready;

    // divider step: one quotient bit per cycle
    always_comb
    begin
        trial    = {rem_reg, dq_reg[ROW_W-1]};
        qbit     = (trial >= {1'b0, gs_eff});
        rem_next = qbit ? GS_W'(trial - {1'b0, gs_eff}) : GS_W'(trial);
        quo_next = {dq_reg[ROW_W-2:0], qbit};
    end

    // neighbour position and column for the current stencil entry
    always_comb
    begin
        x_off      = $signed({2'b0, px_reg}) - $signed({2'b0, half});
        y_off      = $signed({2'b0, py_reg}) - $signed({2'b0, half});
        ncol       = $signed({3'b0, rem_reg}) + 12'(x_off);
        nrow       = $signed({3'b0, dq_reg[GS_W-1:0]}) + 12'(y_off);
        hit        = !ncol[11] && (ncol < $signed({3'b0, gs_eff}))
                     && !nrow[11] && (nrow < $signed({3'b0, gs_eff}));
        col_full   = $signed({2'b0, row_reg}) + 18'(x_off) + yoff_reg;
        walk_final = (px_reg == ss_m1) && (py_reg == ss_m1);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_acc && kind == KIND_GENERATE && gen_ok)
                    state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (bit_cnt_reg == 4'd15)
                    state_next = (quo_next >= {7'b0, gs_eff}) ? ST_IDLE : ST_WALK;
            end
            ST_WALK:
            begin
                if (en && walk_final)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (en)
                    state_next = (s1_hit_reg && pend_valid_reg) ? ST_FLUSH : ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (en)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                ctl.item_ready = 1'b1;
                ctl.tbl_we     = item_acc && (kind == KIND_LOAD)
                                 && (32'(coef_slot) < TBL_DEPTH);
            end
            ST_DIVIDE:
            begin
                ctl = '0;
            end
            ST_WALK:
            begin
                ctl.issue = en;
                if (en && s1_valid_reg && s1_hit_reg)
                begin
                    ctl.pend_load = 1'b1;
                    ctl.out_load  = pend_valid_reg;
                end
            end
            ST_DRAIN:
            begin
                if (en)
                begin
                    if (s1_hit_reg)
                    begin
                        if (pend_valid_reg)
                        begin
                            ctl.out_load  = 1'b1;
                            ctl.pend_load = 1'b1;
                        end
                        else
                        begin
                            ctl.out_load    = 1'b1;
                            ctl.out_from_s1 = 1'b1;
                            ctl.out_last    = 1'b1;
                        end
                    end
                    else if (pend_valid_reg)
                    begin
                        ctl.out_load   = 1'b1;
                        ctl.out_last   = 1'b1;
                        ctl.pend_clear = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (en)
                begin
                    ctl.out_load   = 1'b1;
                    ctl.out_last   = 1'b1;
                    ctl.pend_clear = 1'b1;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            grid_side_reg    <= GS_W'(16);
            stencil_side_reg <= SS_W'(3);
            s1_valid_reg     <= 1'b0;
            pend_valid_reg   <= 1'b0;
            result_valid     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // configuration writes
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_GRID_SIDE:    grid_side_reg    <= cfg_data;
                    REG_STENCIL_SIDE: stencil_side_reg <= cfg_data[SS_W-1:0];
                    default:          grid_side_reg    <= grid_side_reg;
                endcase
            end

            // read stage valid
            if (state_reg == ST_DIVIDE)
                s1_valid_reg <= 1'b0;
            else if (ctl.issue)
                s1_valid_reg <= 1'b1;

            // pending entry valid
            if (ctl.pend_load)
                pend_valid_reg <= 1'b1;
            else if (ctl.pend_clear)
                pend_valid_reg <= 1'b0;

            // result word valid
            if (ctl.out_load)
                result_valid <= 1'b1;
            else if (result_ready)
                result_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        // capture a generate word and set up the walk
        if (item_acc)
        begin
            row_reg     <= grid_row;
            dq_reg      <= grid_row;
            rem_reg     <= '0;
            bit_cnt_reg <= '0;
            px_reg      <= '0;
            py_reg      <= '0;
            p_reg       <= '0;
            yoff_reg    <= -$signed({6'b0, half_gs});
        end
        else if (state_reg == ST_DIVIDE)
        begin
            dq_reg      <= quo_next;
            rem_reg     <= rem_next;
            bit_cnt_reg <= bit_cnt_reg + 4'd1;
        end
        else if (ctl.issue)
        begin
            s1_hit_reg <= hit;
            s1_col_reg <= col_full[ROW_W-1:0];
            p_reg      <= p_reg + TBL_AW'(1);
            if (px_reg == ss_m1)
            begin
                px_reg   <= '0;
                py_reg   <= py_reg + 3'd1;
                yoff_reg <= yoff_reg + $signed({9'b0, gs_eff});
            end
            else
            begin
                px_reg <= px_reg + 3'd1;
            end
        end

        // hold the latest hit until the next one shows whether it is last
        if (ctl.pend_load)
        begin
            pend_col_reg  <= s1_col_reg;
            pend_word_reg <= rd_data_reg;
        end

        // result word
        if (ctl.out_load)
        begin
            matrix_row    <= row_reg;
            matrix_column <= ctl.out_from_s1 ? s1_col_reg : pend_col_reg;
            entry_word    <= WORD_W'(ctl.out_from_s1 ? rd_data_reg : pend_word_reg);
            last_entry    <= ctl.out_last;
        end
    end

    // coefficient memory, one write and one registered read port
    always_ff @(posedge clk)
    begin
        if (ctl.tbl_we)
            coef_mem[TBL_AW'(coef_slot)] <= coef_word[COEF_WIDTH-1:0];
        if (ctl.issue)
            rd_data_reg <= coef_mem[p_reg];
    end

endmodule
